/* hdl/trial_division_factorizer_unit_macros.svh */
// ============================================================================
// Assertion macros for the trial division factorizer
// Shared shorthand for the concurrent checks at the end of the divider and sequencer.
// ============================================================================
`ifndef TRIAL_DIVISION_FACTORIZER_UNIT_MACROS_SVH
`define TRIAL_DIVISION_FACTORIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TDF_ASSERT_IMPLIES(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TDF_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/tdf_pkg.sv */
// ============================================================================
// Trial division factorizer package
// Field widths, status codes and the structs passed between the modules.
// ============================================================================
package tdf_pkg;

	// Fixed widths of the transaction fields.
	localparam int FIELD_WIDTH  = 64;
	localparam int EXP_WIDTH    = 6;
	localparam int STATUS_WIDTH = 2;

	// Default width of the value that is actually factored.
	localparam int VALUE_WIDTH_DEF = 64;

	typedef logic [EXP_WIDTH-1:0]    exp_t;
	typedef logic [STATUS_WIDTH-1:0] status_t;

	// Result status codes.
	localparam status_t ST_FACTOR = 2'd0;
	localparam status_t ST_PRIME  = 2'd1;
	localparam status_t ST_ZERO   = 2'd2;

	localparam exp_t EXP_ZERO = '0;
	localparam exp_t EXP_ONE  = 6'd1;

	// Status of the bit-serial divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	// Result request from the sequencer to the output register.
	typedef struct packed {
		logic    valid;
		logic    last;
		status_t status;
		exp_t    exponent;
	} emit_req_t;

endpackage

/* hdl/tdf_in_if.sv */
// ============================================================================
// Operand channel
// Carries one number to factor per transaction.
// ============================================================================
interface tdf_in_if import tdf_pkg::*; ();

	logic                   valid;
	logic                   ready;
	logic [FIELD_WIDTH-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink (input valid, input number, output ready);

endinterface

/* hdl/tdf_out_if.sv */
// ============================================================================
// Result channel
// Carries one prime factor and its exponent per transaction.
// ============================================================================
interface tdf_out_if import tdf_pkg::*; ();

	logic                   valid;
	logic                   ready;
	logic [FIELD_WIDTH-1:0] factor;
	exp_t                   exponent;
	status_t                status;
	logic                   last;

	modport source (output valid, output factor, output exponent, output status,
		output last, input ready);
	modport sink (input valid, input factor, input exponent, input status,
		input last, output ready);

endinterface

/* hdl/tdf_div.sv */
// ============================================================================
// Bit-serial restoring divider
// Shifts one dividend bit per cycle into the partial remainder.
// ============================================================================
`include "trial_division_factorizer_unit_macros.svh"

module tdf_div import tdf_pkg::*; #(
	parameter int W = VALUE_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output div_sts_t     sts,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0] trial;
	logic [W:0] diff;
	logic       ge;

	// One restoring step: bring in the next dividend bit and try a subtract.
	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = !diff[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q  <= dividend;
				rem_q  <= '0;
				dsr_q  <= divisor;
				cnt_q  <= CW'(W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
				quo_q <= {quo_q[W-2:0], ge};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	`TDF_ASSERT_IMPLIES(a_no_restart, clk, arst_n, start, !busy_q, "divider restarted while busy")
	`TDF_ASSERT_IMPLIES(a_rem_range, clk, arst_n, done_q, rem_q < dsr_q, "remainder not below divisor")
	`TDF_ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q, "done held longer than one cycle")

endmodule

/* hdl/tdf_seq.sv */
// ============================================================================
// Factorization sequencer
// Strips powers of two, then steps odd trial divisors through the divider.
// ============================================================================
`include "trial_division_factorizer_unit_macros.svh"

module tdf_seq import tdf_pkg::*; #(
	parameter int W = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	tdf_in_if.sink                 operand,
	output logic                   div_start,
	output logic [W-1:0]           div_dividend,
	output logic [W-1:0]           div_divisor,
	input  div_sts_t               div_sts,
	input  logic [W-1:0]           div_quotient,
	input  logic [W-1:0]           div_remainder,
	output emit_req_t              emit_req,
	output logic [FIELD_WIDTH-1:0] emit_factor,
	input  logic                   emit_grant
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_STRIP = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_WAIT  = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	logic [2:0]   state_q;
	logic [2:0]   nxt_q;
	logic [W-1:0] r_q;
	logic [W-1:0] d_q;
	exp_t         cnt_q;
	logic         first_q;
	logic         found_q;
	logic [W-1:0] em_factor_q;
	exp_t         em_exp_q;
	status_t      em_status_q;
	logic         em_last_q;

	logic [W-1:0] num;
	logic         r_is_one;

	assign num      = operand.number[W-1:0];
	assign r_is_one = (r_q == W'(1));

	// Main sequence: one shift per cycle while stripping twos, then one
	// bit-serial division per trial.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			nxt_q       <= S_IDLE;
			r_q         <= '0;
			d_q         <= '0;
			cnt_q       <= EXP_ZERO;
			first_q     <= 1'b0;
			found_q     <= 1'b0;
			em_factor_q <= '0;
			em_exp_q    <= EXP_ZERO;
			em_status_q <= ST_FACTOR;
			em_last_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (operand.valid) begin
						if (num == '0) begin
							em_factor_q <= '0;
							em_exp_q    <= EXP_ZERO;
							em_status_q <= ST_ZERO;
							em_last_q   <= 1'b1;
							nxt_q       <= S_IDLE;
							state_q     <= S_EMIT;
						end else if (num == W'(1)) begin
							em_factor_q <= W'(1);
							em_exp_q    <= EXP_ONE;
							em_status_q <= ST_PRIME;
							em_last_q   <= 1'b1;
							nxt_q       <= S_IDLE;
							state_q     <= S_EMIT;
						end else begin
							r_q     <= num;
							cnt_q   <= EXP_ZERO;
							found_q <= 1'b0;
							state_q <= S_STRIP;
						end
					end
				end
				S_STRIP: begin
					if (!r_q[0]) begin
						r_q   <= r_q >> 1;
						cnt_q <= cnt_q + EXP_ONE;
					end else begin
						d_q     <= W'(3);
						first_q <= 1'b1;
						if (cnt_q != EXP_ZERO) begin
							em_factor_q <= W'(2);
							em_exp_q    <= cnt_q;
							em_status_q <= ST_FACTOR;
							em_last_q   <= r_is_one;
							found_q     <= 1'b1;
							cnt_q       <= EXP_ZERO;
							nxt_q       <= r_is_one ? S_IDLE : S_DIV;
							state_q     <= S_EMIT;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_sts.done) begin
						if (first_q && (div_quotient < d_q)) begin
							// Divisor passed the square root: any rest is prime.
							if (r_q > W'(1)) begin
								em_factor_q <= r_q;
								em_exp_q    <= EXP_ONE;
								em_status_q <= found_q ? ST_FACTOR : ST_PRIME;
								em_last_q   <= 1'b1;
								nxt_q       <= S_IDLE;
								state_q     <= S_EMIT;
							end else begin
								state_q <= S_IDLE;
							end
						end else if (div_remainder == '0) begin
							r_q     <= div_quotient;
							cnt_q   <= cnt_q + EXP_ONE;
							first_q <= 1'b0;
							state_q <= S_DIV;
						end else begin
							d_q     <= d_q + W'(2);
							first_q <= 1'b1;
							if (cnt_q != EXP_ZERO) begin
								em_factor_q <= d_q;
								em_exp_q    <= cnt_q;
								em_status_q <= ST_FACTOR;
								em_last_q   <= r_is_one;
								found_q     <= 1'b1;
								cnt_q       <= EXP_ZERO;
								nxt_q       <= r_is_one ? S_IDLE : S_DIV;
								state_q     <= S_EMIT;
							end else begin
								state_q <= S_DIV;
							end
						end
					end
				end
				S_EMIT: begin
					if (emit_grant) begin
						state_q <= nxt_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign operand.ready = (state_q == S_IDLE);

	assign div_start    = (state_q == S_DIV);
	assign div_dividend = r_q;
	assign div_divisor  = d_q;

	assign emit_req.valid    = (state_q == S_EMIT);
	assign emit_req.last     = em_last_q;
	assign emit_req.status   = em_status_q;
	assign emit_req.exponent = em_exp_q;
	assign emit_factor       = FIELD_WIDTH'(em_factor_q);

	`TDF_ASSERT_IMPLIES(a_odd_divisor, clk, arst_n, state_q == S_DIV, d_q[0], "even trial divisor")
	`TDF_ASSERT_IMPLIES(a_prime_alone, clk, arst_n, emit_req.valid && emit_req.status == ST_PRIME, emit_req.last && emit_req.exponent == EXP_ONE, "prime result not single")
	`TDF_ASSERT_NEXT(a_div_launch, clk, arst_n, state_q == S_DIV, state_q == S_WAIT && div_sts.busy, "division did not start")

endmodule

/* hdl/trial_division_factorizer_unit.sv */
// ============================================================================
// Trial division factorizer
// Emits the prime factorization of each number, one result per prime; zero and one give a single result.
// ============================================================================
//
//   channel   dir   payload                              handshake
//   operand   in    number[63:0]                         valid / ready
//   result    out   factor[63:0] exponent status last    valid / ready
//
// Powers of two are stripped one bit per cycle.
// Each odd trial division runs through the bit-serial divider.
// With m the odd part of n, at most about sqrt(m) / 2 + e divisions run,
// e being the sum of the odd exponents.
// arst_n clears all control state; no clearing pass is needed.
// The sequencer holds in place while the result register is full and stalled.
// ============================================================================
module trial_division_factorizer_unit import tdf_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tdf_in_if.sink     operand,
	tdf_out_if.source  result
);

	logic                   div_start;
	logic [VALUE_WIDTH-1:0] div_dividend;
	logic [VALUE_WIDTH-1:0] div_divisor;
	div_sts_t               div_sts;
	logic [VALUE_WIDTH-1:0] div_quotient;
	logic [VALUE_WIDTH-1:0] div_remainder;
	emit_req_t              emit_req;
	logic [FIELD_WIDTH-1:0] emit_factor;
	logic                   emit_grant;

	logic                   out_valid_q;
	logic [FIELD_WIDTH-1:0] out_factor_q;
	exp_t                   out_exp_q;
	status_t                out_status_q;
	logic                   out_last_q;

	tdf_seq #(
		.W (VALUE_WIDTH)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.operand       (operand),
		.div_start     (div_start),
		.div_dividend  (div_dividend),
		.div_divisor   (div_divisor),
		.div_sts       (div_sts),
		.div_quotient  (div_quotient),
		.div_remainder (div_remainder),
		.emit_req      (emit_req),
		.emit_factor   (emit_factor),
		.emit_grant    (emit_grant)
	);

	tdf_div #(
		.W (VALUE_WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.sts       (div_sts),
		.quotient  (div_quotient),
		.remainder (div_remainder)
	);

	// The result register takes a new entry when empty or being drained.
	assign emit_grant = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_req.valid && emit_grant) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, loaded with each transaction from the sequencer.
	always_ff @(posedge clk) begin
		if (emit_req.valid && emit_grant) begin
			out_factor_q <= emit_factor;
			out_exp_q    <= emit_req.exponent;
			out_status_q <= emit_req.status;
			out_last_q   <= emit_req.last;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.factor   = out_factor_q;
	assign result.exponent = out_exp_q;
	assign result.status   = out_status_q;
	assign result.last     = out_last_q;

endmodule
